FILE: rtl/cdq_pkg.sv
`default_nettype none

package cdq_pkg;

   localparam int unsigned DEPTH_DEFAULT = 128;
   localparam int unsigned WORD_W        = 32;
   localparam int unsigned OP_W          = 3;
   localparam int unsigned STATUS_W      = 2;
   localparam int unsigned RSP_USER_W    = 4;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_REAR  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_REAR   = 3'd3,
      OP_PEEK_FRONT = 3'd4,
      OP_PEEK_REAR  = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // where the result word comes from
   typedef enum logic [1:0] {
      RD_ZERO = 2'd0,
      RD_ONES = 2'd1,
      RD_MEM  = 2'd2
   } rd_src_type;

   typedef struct packed {
      rd_src_type rd_src;
      status_type status;
      logic       now_empty;
      logic       now_full;
   } rsp_info_type;

endpackage

`default_nettype wire

FILE: rtl/circular_deque_core.sv
// Double-ended queue of DEPTH signed 32-bit words in a circular RAM.
// Request beat (req_): tuser carries the operation (push front/rear,
// pop front/rear, peek front/rear), tdata the word to push.
// Result beat (rsp_): tdata carries the peeked word (-1 on an empty peek,
// 0 otherwise), tuser the status and the empty/full flags after the op.
// Every request gives exactly one result, in order.
// The head/tail pointers update at the request beat; the RAM read is
// registered, and the result word then passes through the output register.
// Throughput: one request per cycle while results are taken; the single
// RAM port serves the one write of a push or the one read of a peek per beat.
// When rsp_tready is low the result holds in the output register, one more
// request can finish its RAM read behind it, then req_tready drops.
// Reset clears pointers and pipeline valids, leaving the deque empty;
// RAM contents are not cleared and need no clearing pass.
`default_nettype none

module circular_deque_core #(
   parameter int unsigned DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] push_value
   input  wire logic [2:0]  req_tuser,   // [2:0] operation
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [31:0] rsp_tdata,   // [31:0] read_value
   output logic      [3:0]  rsp_tuser    // [1:0] status, [2] now_empty, [3] now_full
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic                          accept;
   logic                          mem_rd_en, mem_wr_en;
   logic [AW-1:0]                 mem_addr;
   logic [cdq_pkg::WORD_W-1:0]    mem_rd_data;
   cdq_pkg::rsp_info_type         info;
   cdq_pkg::rsp_info_type         s1_info_ff;
   logic                          s1_valid_ff, s1_valid_in;
   logic                          out_free, s1_move;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [cdq_pkg::WORD_W-1:0]    rsp_data_ff, rsp_data_in;
   logic [cdq_pkg::RSP_USER_W-1:0] rsp_user_ff;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign accept     = req_tvalid && req_tready;

   cdq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .op        (req_tuser),
      .mem_rd_en (mem_rd_en),
      .mem_wr_en (mem_wr_en),
      .mem_addr  (mem_addr),
      .info      (info)
   );

   cdq_store #(.DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .wr_en   (mem_wr_en),
      .addr    (mem_addr),
      .wr_data (req_tdata),
      .rd_data (mem_rd_data)
   );

   always_comb begin
      s1_valid_in  = accept || (s1_valid_ff && !out_free);
      rsp_valid_in = s1_move || (rsp_valid_ff && !rsp_tready);
      case (s1_info_ff.rd_src)
         cdq_pkg::RD_MEM:  rsp_data_in = mem_rd_data;
         cdq_pkg::RD_ONES: rsp_data_in = '1;
         default:          rsp_data_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         s1_info_ff <= info;
      end
      if (s1_move) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= {s1_info_ff.now_full, s1_info_ff.now_empty, s1_info_ff.status};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

FILE: rtl/cdq_store.sv
`default_nettype none

module cdq_store #(
   parameter int unsigned DEPTH = cdq_pkg::DEPTH_DEFAULT,
   localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                        clock,
   input  wire logic                        rd_en,
   input  wire logic                        wr_en,
   input  wire logic [AW-1:0]               addr,
   input  wire logic [cdq_pkg::WORD_W-1:0]  wr_data,
   output logic      [cdq_pkg::WORD_W-1:0]  rd_data
);

   logic [cdq_pkg::WORD_W-1:0] mem [DEPTH];
   logic [cdq_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/cdq_ctrl.sv
`default_nettype none

module cdq_ctrl #(
   parameter int unsigned DEPTH = cdq_pkg::DEPTH_DEFAULT,
   localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         accept,
   input  wire logic [cdq_pkg::OP_W-1:0]     op,
   output logic                              mem_rd_en,
   output logic                              mem_wr_en,
   output logic      [AW-1:0]                mem_addr,
   output cdq_pkg::rsp_info_type             info
);

   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic          empty_ff, empty_in;
   logic [AW-1:0] head_inc, head_dec, tail_inc, tail_dec, tail_in_inc;
   logic          full_now;
   logic          push_we;
   logic [AW-1:0] addr;
   cdq_pkg::rsp_info_type info_c;

   assign head_inc    = (head_ff == LAST) ? '0 : head_ff + 1'b1;
   assign head_dec    = (head_ff == '0) ? LAST : head_ff - 1'b1;
   assign tail_inc    = (tail_ff == LAST) ? '0 : tail_ff + 1'b1;
   assign tail_dec    = (tail_ff == '0) ? LAST : tail_ff - 1'b1;
   assign tail_in_inc = (tail_in == LAST) ? '0 : tail_in + 1'b1;
   assign full_now    = !empty_ff && (tail_inc == head_ff);

   always_comb begin
      head_in        = head_ff;
      tail_in        = tail_ff;
      empty_in       = empty_ff;
      push_we        = 1'b0;
      addr           = '0;
      info_c.rd_src  = cdq_pkg::RD_ZERO;
      info_c.status  = cdq_pkg::ST_DONE;
      case (cdq_pkg::op_type'(op))
         cdq_pkg::OP_PUSH_FRONT, cdq_pkg::OP_PUSH_REAR: begin
            if (full_now) begin
               info_c.status = cdq_pkg::ST_FULL;
            end else begin
               push_we = 1'b1;
               if (empty_ff) begin
                  head_in  = '0;
                  tail_in  = '0;
                  empty_in = 1'b0;
                  addr     = '0;
               end else if (cdq_pkg::op_type'(op) == cdq_pkg::OP_PUSH_FRONT) begin
                  head_in = head_dec;
                  addr    = head_dec;
               end else begin
                  tail_in = tail_inc;
                  addr    = tail_inc;
               end
            end
         end
         cdq_pkg::OP_POP_FRONT, cdq_pkg::OP_POP_REAR: begin
            if (empty_ff) begin
               info_c.status = cdq_pkg::ST_EMPTY;
            end else if (head_ff == tail_ff) begin
               head_in  = '0;
               tail_in  = '0;
               empty_in = 1'b1;
            end else if (cdq_pkg::op_type'(op) == cdq_pkg::OP_POP_FRONT) begin
               head_in = head_inc;
            end else begin
               tail_in = tail_dec;
            end
         end
         cdq_pkg::OP_PEEK_FRONT, cdq_pkg::OP_PEEK_REAR: begin
            if (empty_ff) begin
               info_c.status = cdq_pkg::ST_EMPTY;
               info_c.rd_src = cdq_pkg::RD_ONES;
            end else begin
               info_c.rd_src = cdq_pkg::RD_MEM;
               addr = (cdq_pkg::op_type'(op) == cdq_pkg::OP_PEEK_FRONT) ? head_ff : tail_ff;
            end
         end
         default: begin
         end
      endcase
      info_c.now_empty = empty_in;
      info_c.now_full  = !empty_in && (tail_in_inc == head_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         empty_ff <= 1'b1;
      end else if (accept) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         empty_ff <= empty_in;
      end
   end

   assign mem_wr_en = accept && push_we;
   assign mem_rd_en = accept && (info_c.rd_src == cdq_pkg::RD_MEM);
   assign mem_addr  = addr;
   assign info      = info_c;

endmodule

`default_nettype wire

FILE: rtl/cdq_checker.sv
`default_nettype none

module cdq_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic [3:0]  rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("not idle right after reset");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[2] && rsp_tuser[3]) &&
         ((rsp_tuser[1:0] == cdq_pkg::ST_DONE) || (rsp_tuser[1:0] == cdq_pkg::ST_FULL) ||
          (rsp_tuser[1:0] == cdq_pkg::ST_EMPTY)))
      else $error("bad status or both empty and full");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[1:0] == cdq_pkg::ST_FULL) |->
         rsp_tuser[3] && (rsp_tdata == 32'd0))
      else $error("full reject without full flag");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[1:0] == cdq_pkg::ST_EMPTY) |->
         rsp_tuser[2] && ((rsp_tdata == 32'd0) || (rsp_tdata == 32'hFFFF_FFFF)))
      else $error("empty reject without empty flag");

endmodule

bind circular_deque_core cdq_checker u_cdq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

FILE: test/deque_checker.sv
`default_nettype none

module deque_checker #(
   parameter int unsigned DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [31:0] req_tdata,
   input  wire logic [2:0]  req_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [31:0] rsp_tdata,
   input  wire logic [3:0]  rsp_tuser,
   output int               mismatch_count,
   output int               results_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [31:0]         read_value;
      cdq_pkg::status_type status;
      logic                now_empty;
      logic                now_full;
   } deque_result_type;

   logic [31:0]      shadow_store [DEPTH];
   int unsigned      front_index = 0;
   int unsigned      rear_index  = 0;
   bit               shadow_empty = 1'b1;
   deque_result_type expected_results [$];
   int               mismatches = 0;
   int               pending_count = 0;
   int               beat_count = 0;

   assign mismatch_count  = mismatches;
   assign results_pending = pending_count;

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("result beat %0d: %s expected %h got %h", beat_count, what, want, got);
      mismatches++;
   endtask

   function automatic bit shadow_full();
      return !shadow_empty && ((rear_index + 1) % DEPTH) == front_index;
   endfunction

   function automatic deque_result_type apply_deque_op(input logic [2:0] op_code,
                                                       input logic [31:0] word);
      deque_result_type r;
      r.read_value = '0;
      r.status     = cdq_pkg::ST_DONE;
      case (op_code)
         cdq_pkg::OP_PUSH_FRONT, cdq_pkg::OP_PUSH_REAR: begin
            if (shadow_full()) begin
               r.status = cdq_pkg::ST_FULL;
            end else begin
               if (shadow_empty) begin
                  front_index  = 0;
                  rear_index   = 0;
                  shadow_empty = 1'b0;
               end else if (op_code == cdq_pkg::OP_PUSH_FRONT) begin
                  front_index = (front_index + DEPTH - 1) % DEPTH;
               end else begin
                  rear_index = (rear_index + 1) % DEPTH;
               end
               if (op_code == cdq_pkg::OP_PUSH_FRONT) shadow_store[front_index] = word;
               else shadow_store[rear_index] = word;
            end
         end
         cdq_pkg::OP_POP_FRONT, cdq_pkg::OP_POP_REAR: begin
            if (shadow_empty) begin
               r.status = cdq_pkg::ST_EMPTY;
            end else if (front_index == rear_index) begin
               front_index  = 0;
               rear_index   = 0;
               shadow_empty = 1'b1;
            end else if (op_code == cdq_pkg::OP_POP_FRONT) begin
               front_index = (front_index + 1) % DEPTH;
            end else begin
               rear_index = (rear_index + DEPTH - 1) % DEPTH;
            end
         end
         cdq_pkg::OP_PEEK_FRONT, cdq_pkg::OP_PEEK_REAR: begin
            if (shadow_empty) begin
               r.status     = cdq_pkg::ST_EMPTY;
               r.read_value = '1;
            end else begin
               r.read_value = (op_code == cdq_pkg::OP_PEEK_FRONT) ? shadow_store[front_index]
                                                                  : shadow_store[rear_index];
            end
         end
         default: ;
      endcase
      r.now_empty = shadow_empty;
      r.now_full  = shadow_full();
      return r;
   endfunction

   always @(posedge clock) begin
      deque_result_type want;
      if (reset) begin
         expected_results.delete();
         front_index  = 0;
         rear_index   = 0;
         shadow_empty = 1'b1;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(apply_deque_op(req_tuser, req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("beat with nothing pending, data", '0, rsp_tdata);
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata !== want.read_value)
                  report_mismatch("read_value", want.read_value, rsp_tdata);
               if (rsp_tuser[1:0] !== want.status)
                  report_mismatch("status", 32'(want.status), 32'(rsp_tuser[1:0]));
               if (rsp_tuser[2] !== want.now_empty)
                  report_mismatch("now_empty", 32'(want.now_empty), 32'(rsp_tuser[2]));
               if (rsp_tuser[3] !== want.now_full)
                  report_mismatch("now_full", 32'(want.now_full), 32'(rsp_tuser[3]));
            end
            beat_count++;
         end
      end
      pending_count <= expected_results.size();
   end

endmodule

`default_nettype wire

FILE: test/tb_circular_deque_core.sv
`default_nettype none

module tb_circular_deque_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;
   localparam int         CYCLE_LIMIT = 400000;
   localparam int         HOLD_CYCLES = 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [3:0]  rsp_tuser;
   int          mismatch_count;
   int          results_pending;
   int          cycle_count = 0;
   bit          no_idle = 1'b0;
   bit          hold_results = 1'b0;

   circular_deque_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   deque_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic int idle_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // percentages for push / pop / peek; the remainder goes to the spare codes
   function automatic logic [2:0] pick_op(input int push_pct, input int pop_pct,
                                          input int peek_pct);
      int r;
      bit rear;
      r    = $urandom_range(0, 99);
      rear = $urandom_range(0, 1);
      if (r < push_pct)
         return rear ? cdq_pkg::OP_PUSH_REAR : cdq_pkg::OP_PUSH_FRONT;
      if (r < push_pct + pop_pct)
         return rear ? cdq_pkg::OP_POP_REAR : cdq_pkg::OP_POP_FRONT;
      if (r < push_pct + pop_pct + peek_pct)
         return rear ? cdq_pkg::OP_PEEK_REAR : cdq_pkg::OP_PEEK_FRONT;
      return rear ? OP_SPARE_HI : OP_SPARE_LO;
   endfunction

   task automatic send_item(input logic [2:0] op_code, input logic [31:0] word);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op_code;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
   endtask

   // result side
   initial begin
      int n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_results) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_results = 1'b0;
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         n = idle_gap();
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
      end
   end

   initial begin
      logic [2:0] op_code;
      int         pushes;
      int         pops;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty deque
      send_item(cdq_pkg::OP_PEEK_FRONT, 32'h1234_5678);
      send_item(cdq_pkg::OP_PEEK_REAR,  32'h8765_4321);
      send_item(cdq_pkg::OP_POP_FRONT,  '0);
      send_item(cdq_pkg::OP_POP_REAR,   '1);
      send_item(OP_SPARE_LO,            32'hdead_beef);
      send_item(OP_SPARE_HI,            '1);
      // extremes of the word
      send_item(cdq_pkg::OP_PUSH_FRONT, 32'h7fff_ffff);
      send_item(cdq_pkg::OP_PUSH_REAR,  32'h8000_0000);
      send_item(cdq_pkg::OP_PEEK_FRONT, '0);
      send_item(cdq_pkg::OP_PEEK_REAR,  '0);
      send_item(cdq_pkg::OP_PUSH_FRONT, 32'h0000_0000);
      send_item(cdq_pkg::OP_PUSH_REAR,  32'hffff_ffff);
      send_item(OP_SPARE_HI,            32'h5555_5555);
      send_item(cdq_pkg::OP_PEEK_FRONT, '0);
      send_item(cdq_pkg::OP_PEEK_REAR,  '0);
      send_item(cdq_pkg::OP_POP_FRONT,  '0);
      send_item(cdq_pkg::OP_POP_REAR,   '0);
      send_item(cdq_pkg::OP_PEEK_FRONT, '0);
      send_item(cdq_pkg::OP_PEEK_REAR,  '0);
      // last element leaves by either end
      send_item(cdq_pkg::OP_POP_FRONT,  '0);
      send_item(cdq_pkg::OP_POP_REAR,   '0);
      send_item(cdq_pkg::OP_PUSH_REAR,  32'h5a5a_5a5a);
      send_item(cdq_pkg::OP_POP_FRONT,  '0);
      send_item(cdq_pkg::OP_PEEK_REAR,  '0);

      // fill past full while results are held off for a while
      hold_results = 1'b1;
      pushes = 0;
      while (pushes < 140) begin
         op_code = pick_op(85, 0, 13);
         if (op_code == cdq_pkg::OP_PUSH_FRONT || op_code == cdq_pkg::OP_PUSH_REAR)
            pushes++;
         send_item(op_code, $urandom);
      end

      // drain past empty
      pops = 0;
      while (pops < 140) begin
         op_code = pick_op(0, 85, 13);
         if (op_code == cdq_pkg::OP_POP_FRONT || op_code == cdq_pkg::OP_POP_REAR)
            pops++;
         send_item(op_code, $urandom);
      end

      req_tvalid <= 1'b0;
      wait_drained();

      for (int i = 0; i < 220; i++) begin
         no_idle = (i >= 110 && i < 160);
         send_item(pick_op(45, 35, 15), $urandom);
      end
      no_idle = 1'b0;

      req_tvalid <= 1'b0;
      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && results_pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
